/* sv/aea_pkg.sv */
// Shared types, widths and register codes of the array element address unit.
package aea_pkg;

  localparam int unsigned NUM_INDEX_FIELDS = 4;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned BASE_W = 31;
  localparam int unsigned ESIZE_W = 16;
  localparam int unsigned NDIMS_W = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam int unsigned DEFAULT_MAX_DIMS = 4;
  localparam int unsigned DEFAULT_INDEX_WIDTH = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 3'd0,
    REG_ELEMENT_SIZE = 3'd1,
    REG_NUM_DIMS     = 3'd2,
    REG_LOWER_BOUNDS = 3'd3,
    REG_UPPER_BOUNDS = 3'd4
  } cfg_reg_e;

  // Configuration seen by the front stage.
  typedef struct packed {
    logic [BASE_W-1:0]     base;
    logic [ESIZE_W-1:0]    esize;
    logic [CFG_DATA_W-1:0] lower;
    logic [CFG_DATA_W-1:0] upper;
  } aea_cfg_t;

  // One word in flight between pipeline stages.
  typedef struct packed {
    logic [ADDR_W-1:0]                        addr;
    logic [ADDR_W-1:0]                        stride;
    logic [NUM_INDEX_FIELDS-1:0][ADDR_W-1:0]  diff;
    logic [NUM_INDEX_FIELDS-1:0][ADDR_W-1:0]  ext;
  } aea_item_t;

endpackage

/* sv/aea_prep.sv */
// Front stage: unpacks the bounds and forms index offsets and extents per dimension.
module aea_prep #(
  parameter int unsigned INDEX_WIDTH = aea_pkg::DEFAULT_INDEX_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [aea_pkg::FIELD_W-1:0]  index_first_i,
  input  logic signed [aea_pkg::FIELD_W-1:0]  index_second_i,
  input  logic signed [aea_pkg::FIELD_W-1:0]  index_third_i,
  input  logic signed [aea_pkg::FIELD_W-1:0]  index_fourth_i,
  input  aea_pkg::aea_cfg_t                   cfg_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output aea_pkg::aea_item_t                  item_o
);
  import aea_pkg::*;

  logic signed [FIELD_W-1:0] idx_in [NUM_INDEX_FIELDS];
  logic [ADDR_W-1:0]         lo_ext [NUM_INDEX_FIELDS];
  logic [ADDR_W-1:0]         hi_ext [NUM_INDEX_FIELDS];
  aea_item_t                 item_d, item_q;
  logic                      valid_q;

  assign idx_in[0] = index_first_i;
  assign idx_in[1] = index_second_i;
  assign idx_in[2] = index_third_i;
  assign idx_in[3] = index_fourth_i;

  // A bound slot that starts beyond the packed register reads as zero.
  for (genvar d = 0; d < NUM_INDEX_FIELDS; d++) begin : g_bound
    localparam int unsigned SH = d * INDEX_WIDTH;
    if (SH < CFG_DATA_W) begin : g_in
      logic [CFG_DATA_W-1:0] lo_sh, hi_sh;
      assign lo_sh = cfg_i.lower >> SH;
      assign hi_sh = cfg_i.upper >> SH;
      assign lo_ext[d] = ADDR_W'($signed(lo_sh[INDEX_WIDTH-1:0]));
      assign hi_ext[d] = ADDR_W'($signed(hi_sh[INDEX_WIDTH-1:0]));
    end else begin : g_out
      assign lo_ext[d] = '0;
      assign hi_ext[d] = '0;
    end
  end

  always_comb begin
    item_d.addr   = ADDR_W'(cfg_i.base);
    item_d.stride = ADDR_W'(cfg_i.esize);
    for (int d = 0; d < NUM_INDEX_FIELDS; d++) begin
      item_d.diff[d] = ADDR_W'(idx_in[d]) - lo_ext[d];
      item_d.ext[d]  = hi_ext[d] - lo_ext[d] + ADDR_W'(1);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* sv/aea_dim_stage.sv */
// One pipeline stage that folds a single dimension into the address and stride.
module aea_dim_stage #(
  parameter int unsigned DIM = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [aea_pkg::NDIMS_W-1:0]   dims_used_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  aea_pkg::aea_item_t            item_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output aea_pkg::aea_item_t            item_o
);
  import aea_pkg::*;

  aea_item_t         item_d, item_q;
  logic              valid_q;
  logic [ADDR_W-1:0] addr_prod;
  logic [ADDR_W-1:0] stride_prod;

  // Both products wrap to the low 32 bits.
  assign addr_prod   = item_i.stride * item_i.diff[DIM];
  assign stride_prod = item_i.stride * item_i.ext[DIM];

  always_comb begin
    item_d = item_i;
    if (NDIMS_W'(DIM) < dims_used_i) begin
      item_d.addr   = item_i.addr + addr_prod;
      item_d.stride = stride_prod;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* sv/array_element_address_unit.sv */
// Top level of the row-major array element address unit.
// Computes base + sum of stride * (index - lower bound) over the dimensions in
// use, wrapping at 32 bits, with dimension one varying slowest. It takes one
// word per cycle while the output is not stalled and returns one address per
// word in order. It has a front stage that forms offsets and extents, one
// multiply-accumulate stage per dimension (last dimension first), and an
// output register. Each stage holds its word under stall, so a new word is
// taken whenever any stage has room.
// Configuration registers are written through cfg_we_i and should change
// only while no word is in flight.
module array_element_address_unit #(
  parameter int unsigned MAX_DIMS    = aea_pkg::DEFAULT_MAX_DIMS,
  parameter int unsigned INDEX_WIDTH = aea_pkg::DEFAULT_INDEX_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [aea_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [aea_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [aea_pkg::FIELD_W-1:0]   index_first_i,
  input  logic signed [aea_pkg::FIELD_W-1:0]   index_second_i,
  input  logic signed [aea_pkg::FIELD_W-1:0]   index_third_i,
  input  logic signed [aea_pkg::FIELD_W-1:0]   index_fourth_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [aea_pkg::ADDR_W-1:0]    element_address_o
);
  import aea_pkg::*;

  localparam int unsigned NUM_STAGES =
    (MAX_DIMS < NUM_INDEX_FIELDS) ? MAX_DIMS : NUM_INDEX_FIELDS;

  logic [BASE_W-1:0]     base_q;
  logic [ESIZE_W-1:0]    esize_q;
  logic [NDIMS_W-1:0]    ndims_q;
  logic [CFG_DATA_W-1:0] lower_q;
  logic [CFG_DATA_W-1:0] upper_q;
  aea_cfg_t              cfg;
  logic [NDIMS_W-1:0]    dims_used;

  logic      pipe_valid [NUM_STAGES+1];
  logic      pipe_ready [NUM_STAGES+1];
  aea_item_t pipe_item  [NUM_STAGES+1];

  logic              out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      esize_q <= ESIZE_W'(1);
      ndims_q <= NDIMS_W'(1);
      lower_q <= '0;
      upper_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BASE_ADDRESS: base_q  <= cfg_wdata_i[BASE_W-1:0];
        REG_ELEMENT_SIZE: esize_q <= cfg_wdata_i[ESIZE_W-1:0];
        REG_NUM_DIMS:     ndims_q <= cfg_wdata_i[NDIMS_W-1:0];
        REG_LOWER_BOUNDS: lower_q <= cfg_wdata_i;
        REG_UPPER_BOUNDS: upper_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg.base  = base_q;
  assign cfg.esize = esize_q;
  assign cfg.lower = lower_q;
  assign cfg.upper = upper_q;

  // A count of zero means one dimension; larger counts saturate.
  always_comb begin
    dims_used = ndims_q;
    if (ndims_q == '0) begin
      dims_used = NDIMS_W'(1);
    end else if (ndims_q > NDIMS_W'(NUM_STAGES)) begin
      dims_used = NDIMS_W'(NUM_STAGES);
    end
  end

  aea_prep #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_prep (
    .clk_i,
    .rst_ni,
    .valid_i        (in_valid_i),
    .ready_o        (in_ready_o),
    .index_first_i,
    .index_second_i,
    .index_third_i,
    .index_fourth_i,
    .cfg_i          (cfg),
    .valid_o        (pipe_valid[0]),
    .ready_i        (pipe_ready[0]),
    .item_o         (pipe_item[0])
  );

  // The last dimension is folded in first, so its stride is the element size.
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_dim
    aea_dim_stage #(
      .DIM(NUM_STAGES - 1 - s)
    ) u_dim (
      .clk_i,
      .rst_ni,
      .dims_used_i (dims_used),
      .valid_i     (pipe_valid[s]),
      .ready_o     (pipe_ready[s]),
      .item_i      (pipe_item[s]),
      .valid_o     (pipe_valid[s+1]),
      .ready_i     (pipe_ready[s+1]),
      .item_o      (pipe_item[s+1])
    );
  end

  assign pipe_ready[NUM_STAGES] = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_ready[NUM_STAGES]) begin
      out_valid_q <= pipe_valid[NUM_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_valid[NUM_STAGES] && pipe_ready[NUM_STAGES]) begin
      out_addr_q <= pipe_item[NUM_STAGES].addr;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign element_address_o = out_addr_q;

  a_dims_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dims_used >= NDIMS_W'(1) && dims_used <= NDIMS_W'(NUM_STAGES))
    else $error("dimension count out of range");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while output drains");

  a_full_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without an output stall");

endmodule
